>>> hw/rtl/krc_pkg.sv
// Shared types, constants and functions for the key binding remap table.
// No dependencies; used by the interfaces, the slot cell and the top level.
package krc_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 6;
  localparam int DEFAULT_SLOTS = 38;

  typedef enum logic [1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_BIND    = 2'd1,
    ACT_RESTORE = 2'd2
  } action_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  // Keysyms used by the default map and the fold
  localparam logic [KEY_W-1:0] KEY_TAB     = 32'h0000_FF09;
  localparam logic [KEY_W-1:0] KEY_LEFT    = 32'h0000_FF51;
  localparam logic [KEY_W-1:0] KEY_UP      = 32'h0000_FF52;
  localparam logic [KEY_W-1:0] KEY_RIGHT   = 32'h0000_FF53;
  localparam logic [KEY_W-1:0] KEY_DOWN    = 32'h0000_FF54;
  localparam logic [KEY_W-1:0] KEY_F5      = 32'h0000_FFC2;
  localparam logic [KEY_W-1:0] KEY_F6      = 32'h0000_FFC3;
  localparam logic [KEY_W-1:0] KEY_SHIFT_L = 32'h0000_FFE1;
  localparam logic [KEY_W-1:0] KEY_CTRL_L  = 32'h0000_FFE3;
  localparam logic [KEY_W-1:0] KEY_ALT_L   = 32'h0000_FFE9;
  localparam logic [KEY_W-1:0] KEY_KP_MUL  = 32'h0000_FFAA;
  localparam logic [KEY_W-1:0] KEY_KP_DIV  = 32'h0000_FFAF;
  localparam logic [KEY_W-1:0] KEY_KP_0    = 32'h0000_FFB0;
  localparam logic [KEY_W-1:0] KEY_KP_9    = 32'h0000_FFB9;
  localparam logic [KEY_W-1:0] KEY_UC_A    = 32'h0000_0041;
  localparam logic [KEY_W-1:0] KEY_UC_Z    = 32'h0000_005A;
  localparam logic [KEY_W-1:0] KEY_DIGIT_0 = 32'h0000_0030;
  localparam logic [KEY_W-1:0] KEY_STAR    = 32'h0000_002A;
  localparam logic [KEY_W-1:0] KEY_HASH    = 32'h0000_0023;
  localparam logic [KEY_W-1:0] KEY_CASE    = 32'h0000_0020;

  // Command broadcast to every slot cell on an input transfer
  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  folded;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok; // target slot exists
  } cell_cmd_t;

  function automatic logic [KEY_W-1:0] default_code(input int unsigned idx);
    logic [KEY_W-1:0] code;
    code = '0;
    case (idx)
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: code = KEY_DIGIT_0 + KEY_W'(idx);
      10: code = KEY_STAR;
      11: code = KEY_HASH;
      12: code = KEY_UP;
      13: code = KEY_DOWN;
      14: code = KEY_LEFT;
      15: code = KEY_RIGHT;
      16: code = KEY_CTRL_L;
      17: code = KEY_ALT_L;
      30: code = 32'h0000_0077; // 'w'
      31: code = 32'h0000_0073; // 's'
      32: code = 32'h0000_0061; // 'a'
      33: code = 32'h0000_0064; // 'd'
      34: code = KEY_SHIFT_L;
      35: code = KEY_TAB;
      36: code = KEY_F5;
      37: code = KEY_F6;
      default: code = '0;
    endcase
    return code;
  endfunction

  function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] f;
    f = k;
    if (k >= KEY_UC_A && k <= KEY_UC_Z) begin
      f = k + KEY_CASE;
    end else if (k >= KEY_KP_0 && k <= KEY_KP_9) begin
      f = KEY_DIGIT_0 + (k - KEY_KP_0);
    end else if (k == KEY_KP_MUL) begin
      f = KEY_STAR;
    end else if (k == KEY_KP_DIV) begin
      f = KEY_HASH;
    end
    return f;
  endfunction

endpackage

>>> hw/rtl/krc_if.sv
// Valid/ready channel interfaces for the key binding remap table.
// Depends on krc_pkg for field widths.
interface krc_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [krc_pkg::KEY_W-1:0] key_code;
  logic [krc_pkg::SLOT_W-1:0] slot;

  modport source (output valid, action, key_code, slot, input ready);
  modport sink   (input valid, action, key_code, slot, output ready);
endinterface

interface krc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [krc_pkg::SLOT_W-1:0] slot_found;

  modport source (output valid, hit, slot_found, input ready);
  modport sink   (input valid, hit, slot_found, output ready);
endinterface

>>> hw/rtl/krc_cell.sv
// One slot of the binding table: holds its key code, applies bind/restore,
// registers its match and takes part in the lowest-slot priority chain.
// Depends on krc_pkg.
module krc_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  krc_pkg::cell_cmd_t  cmd,
  input  logic                taken_in,
  output logic                taken_out,
  output logic                first
);

  localparam logic [krc_pkg::SLOT_W-1:0] MY_SLOT = krc_pkg::SLOT_W'(IDX);
  localparam logic [krc_pkg::KEY_W-1:0]  DEF     = krc_pkg::default_code(IDX);

  logic [krc_pkg::KEY_W-1:0] code;
  logic                      match_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      code    <= DEF;
      match_q <= 1'b0;
    end else if (en) begin
      match_q <= (cmd.action == krc_pkg::ACT_LOOKUP) && (code != '0) &&
                 ((code == cmd.key) || (code == cmd.folded));
      case (cmd.action)
        krc_pkg::ACT_BIND: begin
          // a bind to a missing slot leaves every slot alone
          if (cmd.slot_ok && cmd.slot == MY_SLOT) begin
            code <= cmd.key;
          end else if (cmd.slot_ok && cmd.key != '0 && code == cmd.key) begin
            code <= '0; // key stolen by another slot
          end
        end
        krc_pkg::ACT_RESTORE: code <= DEF;
        default: ;
      endcase
    end
  end

  // lower slot wins: pass "already found" up the chain
  assign first     = match_q & ~taken_in;
  assign taken_out = match_q | taken_in;

endmodule

>>> hw/rtl/key_binding_remap_cam.sv
// Key binding remap table: a row of SLOT_COUNT slot cells, each holding one
// key code (zero = unbound), reset to the default map. A request passes two
// states: the transfer, in which all cells compare against the raw and folded
// key and apply a bind (stealing the key from other slots) or a restore, then
// the result state, in which the priority chain through the cells picks the
// lowest matching slot and the result is loaded into the output register once
// that register is empty or the sink takes it. A new request is taken once
// the result is loaded; the output register holds it while the sink stalls.
module key_binding_remap_cam #(
  parameter int SLOT_COUNT = 38
) (
  input logic        clk,
  input logic        rst,
  krc_req_if.sink    req,
  krc_rsp_if.source  rsp
);

  localparam int SW = krc_pkg::SLOT_W;

  krc_pkg::state_t    state, state_next;
  krc_pkg::cell_cmd_t cmd;
  krc_pkg::action_t   act_q;
  logic               bind_ok_q;
  logic               accept;
  logic               load_rsp;

  logic [SLOT_COUNT:0]   taken;
  logic [SLOT_COUNT-1:0] first;
  logic [SW-1:0]         enc;

  logic          rsp_valid;
  logic          rsp_hit;
  logic [SW-1:0] rsp_slot;

  assign req.ready = (state == krc_pkg::S_IDLE);
  assign accept    = req.valid & req.ready;

  always_comb begin
    cmd.action  = krc_pkg::action_t'(req.action);
    cmd.key     = req.key_code;
    cmd.folded  = krc_pkg::fold_key(req.key_code);
    cmd.slot    = req.slot;
    cmd.slot_ok = ({1'b0, req.slot} < (SW+1)'(SLOT_COUNT));
  end

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    krc_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (accept),
      .cmd       (cmd),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .first     (first[i])
    );
  end

  // first is one-hot or empty, so an OR of the indexes encodes it
  always_comb begin
    enc = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (first[i]) begin
        enc = enc | SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q     <= krc_pkg::action_t'(req.action);
      bind_ok_q <= cmd.slot_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= krc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    case (state)
      krc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = krc_pkg::S_RESULT;
        end
      end
      krc_pkg::S_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = krc_pkg::S_IDLE;
        end
      end
      default: state_next = krc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      case (act_q)
        krc_pkg::ACT_LOOKUP: begin
          rsp_hit  <= taken[SLOT_COUNT];
          rsp_slot <= enc;
        end
        krc_pkg::ACT_BIND: begin
          rsp_hit  <= bind_ok_q;
          rsp_slot <= '0;
        end
        default: begin
          rsp_hit  <= 1'b0;
          rsp_slot <= '0;
        end
      endcase
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.slot_found = rsp_slot;

`ifndef SYNTHESIS
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == krc_pkg::S_RESULT))
    else $error("transfer did not move to result state");

  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == krc_pkg::S_RESULT) |-> $onehot0(first))
    else $error("priority chain selected more than one slot");

  a_slot_implies_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_slot != '0) |-> rsp_hit)
    else $error("nonzero slot reported without hit");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, rsp_slot} < (SW+1)'(SLOT_COUNT)))
    else $error("reported slot out of range");
`endif

endmodule
